// ===== rtl/tbpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpp_pkg
// Types and constants shared by the background pixel pipeline.
// ----------------------------------------------------------------------------
package tbpp_pkg;

   localparam int unsigned VRAM_BYTES = 8192;
   localparam int unsigned VRAM_AW = 13;

   localparam logic [8:0] LINE_DOTS   = 9'd456;
   localparam logic [8:0] SEARCH_DOTS = 9'd80;
   localparam logic [7:0] FRAME_LINES = 8'd154;

   localparam logic [1:0] CSR_LCD_CONTROL = 2'd0;
   localparam logic [1:0] CSR_SCROLL_X    = 2'd1;
   localparam logic [1:0] CSR_SCROLL_Y    = 2'd2;
   localparam logic [1:0] CSR_BG_PALETTE  = 2'd3;

   localparam logic [7:0] LCDC_RESET    = 8'd145;
   localparam logic [7:0] PALETTE_RESET = 8'd252;

   typedef enum logic [1:0] {
      VM_SEARCH   = 2'd0,
      VM_TRANSFER = 2'd1,
      VM_HBLANK   = 2'd2,
      VM_VBLANK   = 2'd3
   } video_mode_type;

   typedef enum logic [2:0] {
      PH_INDEX = 3'd0,
      PH_LOW   = 3'd1,
      PH_HIGH  = 3'd2,
      PH_WAIT  = 3'd3,
      PH_PUSH  = 3'd4
   } fetch_phase_type;

   typedef struct packed {
      logic tick;
      logic push;
      logic flush;
   } queue_ctl_type;

   typedef struct packed {
      logic       pop;
      logic [1:0] head;
      logic       room;
   } queue_status_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [1:0]  shade;
      logic [23:0] rgb_colour;
      logic [7:0]  current_line;
      logic [1:0]  video_mode;
   } rsp_type;

   function automatic logic [23:0] shade_rgb(input logic [1:0] shade);
      logic [23:0] rgb;
      case (shade)
         2'd0:    rgb = 24'hC8C7A8;
         2'd1:    rgb = 24'hA0A088;
         2'd2:    rgb = 24'h686850;
         default: rgb = 24'h272818;
      endcase
      return rgb;
   endfunction

endpackage

// ===== rtl/tbpp_pixel_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpp_pixel_queue
// Shifting colour index queue: pushes eight indices at the tail, pops the
// head on transfer ticks once more than eight are held.
// ----------------------------------------------------------------------------
module tbpp_pixel_queue
   import tbpp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_ctl_type    ctl,
   input  logic [7:0]       plane_low,
   input  logic [7:0]       plane_high,
   output queue_status_type status
);

   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SW = CW + 1;

   logic [1:0]    queue_ff [QUEUE_DEPTH];
   logic [1:0]    queue_in [QUEUE_DEPTH];
   logic [1:0]    merged   [QUEUE_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] sum;
   logic [SW-1:0] filled;
   logic [SW-1:0] offset;
   logic          pop;

   always_comb begin
      sum = {1'b0, count_ff} + SW'(8);
      if (!ctl.push) begin
         filled = {1'b0, count_ff};
      end else if (sum > SW'(QUEUE_DEPTH)) begin
         filled = SW'(QUEUE_DEPTH);
      end else begin
         filled = sum;
      end
      pop = ctl.tick && (filled > SW'(8));

      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         offset = SW'(i) - {1'b0, count_ff};
         if (ctl.push && (SW'(i) >= {1'b0, count_ff}) && (SW'(i) < sum)) begin
            merged[i] = {plane_high[3'd7 - offset[2:0]], plane_low[3'd7 - offset[2:0]]};
         end else begin
            merged[i] = queue_ff[i];
         end
      end

      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i + 1 < QUEUE_DEPTH)) begin
            queue_in[i] = merged[i + 1];
         end else begin
            queue_in[i] = merged[i];
         end
      end

      if (ctl.flush) begin
         count_in = '0;
      end else begin
         count_in = filled[CW-1:0] - CW'(pop);
      end

      status.pop  = pop;
      status.head = merged[0];
      status.room = count_ff <= CW'(9);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

endmodule

// ===== rtl/tile_background_pixel_pipeline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_pixel_pipeline
// Background tile video block: dot timing, tile fetcher over a single port
// video memory, colour index queue and palette shading.
// ----------------------------------------------------------------------------
// Output: each item's result is registered into a two-entry result buffer.
// Throughput: one item per cycle while req_stall is low; the memory port serves
// one read or write per item; read data goes via rd_data_ff to the tile registers.
// Reset: control state cleared, then a pass over all 8192 bytes zeroes video
// memory while req_stall is held high; register writes are taken throughout.
module tile_background_pixel_pipeline
   import tbpp_pkg::*;
#(
   parameter int unsigned SCREEN_COLUMNS = 160,
   parameter int unsigned VISIBLE_LINES  = 144,
   parameter int unsigned QUEUE_DEPTH    = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_kind,
   input  logic [12:0]  req_vram_address,
   input  logic [7:0]   req_vram_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_pixel_valid,
   output logic [7:0]   rsp_pixel_x,
   output logic [7:0]   rsp_pixel_y,
   output logic [1:0]   rsp_shade,
   output logic [23:0]  rsp_rgb_colour,
   output logic [7:0]   rsp_current_line,
   output logic [1:0]   rsp_video_mode,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_write_data
);

   logic [7:0] lcd_control_ff, scroll_x_ff, scroll_y_ff, bg_palette_ff;

   logic [7:0]         vram [VRAM_BYTES];
   logic [7:0]         rd_data_ff;
   logic               rd_en;
   logic [VRAM_AW-1:0] rd_addr;
   logic               clear_ff;
   logic [VRAM_AW-1:0] clear_addr_ff;

   video_mode_type  mode_ff, mode_in;
   fetch_phase_type phase_ff, phase_in;
   fetch_phase_type load_phase_ff, load_phase_in;
   logic            load_ff, load_in;
   logic [8:0]      dot_ff, dot_in;
   logic [7:0]      line_ff, line_in;
   logic [7:0]      out_col_ff, out_col_in;
   logic            half_ff, half_in;
   logic [7:0]      fetch_col_ff, fetch_col_in;
   logic [2:0]      tile_row_ff, tile_row_in;
   logic [7:0]      fetched_tile_ff, plane_low_ff, plane_high_ff;

   logic [7:0]         map_y, map_x;
   logic [VRAM_AW-1:0] map_addr, tile_addr;
   logic [1:0]         color_idx;

   queue_ctl_type    q_ctl;
   queue_status_type q_st;

   logic    accept, tick, pop_out;
   rsp_type result;
   rsp_type slot0_ff, slot1_ff;
   logic [1:0] buf_count_ff;

   assign accept  = req_valid && !req_stall;
   assign tick    = accept && !req_kind && lcd_control_ff[7];
   assign pop_out = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_control_ff <= LCDC_RESET;
         scroll_x_ff    <= '0;
         scroll_y_ff    <= '0;
         bg_palette_ff  <= PALETTE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LCD_CONTROL: lcd_control_ff <= csr_write_data;
            CSR_SCROLL_X:    scroll_x_ff    <= csr_write_data;
            CSR_SCROLL_Y:    scroll_y_ff    <= csr_write_data;
            CSR_BG_PALETTE:  bg_palette_ff  <= csr_write_data;
         endcase
      end
   end

   // map and tile row addresses (offsets from the start of video memory)
   always_comb begin
      map_y     = scroll_y_ff + line_ff;
      map_x     = scroll_x_ff + fetch_col_ff;
      map_addr  = {2'b11, lcd_control_ff[3], map_y[7:3], map_x[7:3]};
      tile_addr = {~lcd_control_ff[4] & ~fetched_tile_ff[7], fetched_tile_ff,
                   tile_row_ff, 1'b0};
   end

   tbpp_pixel_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctl        (q_ctl),
      .plane_low  (plane_low_ff),
      .plane_high (plane_high_ff),
      .status     (q_st)
   );

   always_comb begin
      mode_in       = mode_ff;
      phase_in      = phase_ff;
      load_in       = 1'b0;
      load_phase_in = load_phase_ff;
      dot_in        = dot_ff;
      line_in       = line_ff;
      out_col_in    = out_col_ff;
      half_in       = half_ff;
      fetch_col_in  = fetch_col_ff;
      tile_row_in   = tile_row_ff;
      rd_en         = 1'b0;
      rd_addr       = map_addr;
      q_ctl         = '0;
      result        = '0;
      color_idx     = '0;

      if (tick) begin
         dot_in = dot_ff + 9'd1;
         unique case (mode_ff)
            VM_SEARCH: begin
               if (dot_in == SEARCH_DOTS) begin
                  q_ctl.flush  = 1'b1;
                  phase_in     = PH_INDEX;
                  half_in      = 1'b0;
                  fetch_col_in = '0;
                  mode_in      = VM_TRANSFER;
               end
            end
            VM_TRANSFER: begin
               q_ctl.tick = 1'b1;
               case (phase_ff) inside
                  PH_INDEX, PH_LOW, PH_HIGH: begin
                     if (!half_ff) begin
                        half_in = 1'b1;
                     end else begin
                        half_in       = 1'b0;
                        rd_en         = 1'b1;
                        load_in       = 1'b1;
                        load_phase_in = phase_ff;
                        case (phase_ff)
                           PH_INDEX: begin
                              rd_addr      = map_addr;
                              tile_row_in  = map_y[2:0];
                              fetch_col_in = fetch_col_ff + 8'd8;
                              phase_in     = PH_LOW;
                           end
                           PH_LOW: begin
                              rd_addr  = tile_addr;
                              phase_in = PH_HIGH;
                           end
                           default: begin
                              rd_addr  = tile_addr | VRAM_AW'(1);
                              phase_in = PH_WAIT;
                           end
                        endcase
                     end
                  end
                  PH_WAIT: begin
                     if (q_st.room) begin
                        phase_in = PH_PUSH;
                     end
                  end
                  default: begin
                     phase_in   = PH_INDEX;
                     half_in    = 1'b0;
                     q_ctl.push = 1'b1;
                  end
               endcase
               if (q_st.pop) begin
                  color_idx          = lcd_control_ff[0] ? q_st.head : 2'd0;
                  result.pixel_valid = 1'b1;
                  result.shade       = bg_palette_ff[{color_idx, 1'b0} +: 2];
                  result.rgb_colour  = shade_rgb(result.shade);
                  result.pixel_x     = out_col_ff;
                  result.pixel_y     = line_ff;
                  out_col_in         = out_col_ff + 8'd1;
               end
               if (out_col_in == 8'(SCREEN_COLUMNS)) begin
                  out_col_in = '0;
                  mode_in    = VM_HBLANK;
               end
            end
            VM_HBLANK: begin
               if (dot_in >= LINE_DOTS) begin
                  dot_in  = '0;
                  line_in = line_ff + 8'd1;
                  mode_in = (line_in == 8'(VISIBLE_LINES)) ? VM_VBLANK : VM_SEARCH;
               end
            end
            VM_VBLANK: begin
               if (dot_in >= LINE_DOTS) begin
                  dot_in  = '0;
                  line_in = line_ff + 8'd1;
                  if (line_in >= FRAME_LINES) begin
                     line_in    = '0;
                     out_col_in = '0;
                     mode_in    = VM_SEARCH;
                  end
               end
            end
         endcase
      end

      result.current_line = line_in;
      result.video_mode   = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= VM_SEARCH;
         phase_ff        <= PH_INDEX;
         load_ff         <= 1'b0;
         load_phase_ff   <= PH_INDEX;
         dot_ff          <= '0;
         line_ff         <= '0;
         out_col_ff      <= '0;
         half_ff         <= 1'b0;
         fetch_col_ff    <= '0;
         tile_row_ff     <= '0;
         fetched_tile_ff <= '0;
         plane_low_ff    <= '0;
         plane_high_ff   <= '0;
      end else begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         load_ff       <= load_in;
         load_phase_ff <= load_phase_in;
         dot_ff        <= dot_in;
         line_ff       <= line_in;
         out_col_ff    <= out_col_in;
         half_ff       <= half_in;
         fetch_col_ff  <= fetch_col_in;
         tile_row_ff   <= tile_row_in;
         if (load_ff) begin
            case (load_phase_ff)
               PH_INDEX: fetched_tile_ff <= rd_data_ff;
               PH_LOW:   plane_low_ff    <= rd_data_ff;
               PH_HIGH:  plane_high_ff   <= rd_data_ff;
               default:  ;
            endcase
         end
      end
   end

   // video memory: clearing pass, item writes, fetcher reads
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + VRAM_AW'(1);
         if (clear_addr_ff == '1) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         vram[clear_addr_ff] <= '0;
      end else if (accept && req_kind) begin
         vram[req_vram_address] <= req_vram_data;
      end
      if (rd_en) begin
         rd_data_ff <= vram[rd_addr];
      end
   end

   // two-entry result buffer
   assign req_stall = clear_ff || (buf_count_ff == 2'd2);
   assign rsp_valid = buf_count_ff != 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_count_ff <= '0;
      end else begin
         buf_count_ff <= buf_count_ff + 2'(accept) - 2'(pop_out);
      end
   end

   always_ff @(posedge clock) begin
      case (buf_count_ff)
         2'd0: begin
            if (accept) begin
               slot0_ff <= result;
            end
         end
         2'd1: begin
            if (accept && pop_out) begin
               slot0_ff <= result;
            end else if (accept) begin
               slot1_ff <= result;
            end
         end
         default: begin
            if (pop_out) begin
               slot0_ff <= slot1_ff;
            end
         end
      endcase
   end

   assign rsp_pixel_valid  = slot0_ff.pixel_valid;
   assign rsp_pixel_x      = slot0_ff.pixel_x;
   assign rsp_pixel_y      = slot0_ff.pixel_y;
   assign rsp_shade        = slot0_ff.shade;
   assign rsp_rgb_colour   = slot0_ff.rgb_colour;
   assign rsp_current_line = slot0_ff.current_line;
   assign rsp_video_mode   = slot0_ff.video_mode;

endmodule

// ===== bench/tb_tile_background_pixel_pipeline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_background_pixel_pipeline
// Self-checking bench for the background pixel pipeline. A directed table
// covers reset state, memory extremes and ignored tick fields. Random phases
// then mix dot ticks with map and tile writes under several register
// settings, including display off, background off and both tile areas.
// Each result is predicted in the bench or given literally and checked per field.
// ----------------------------------------------------------------------------
module tb_tile_background_pixel_pipeline;
   import tbpp_pkg::*;

   localparam int unsigned SCREEN_COLUMNS = 160;
   localparam int unsigned VISIBLE_LINES  = 144;
   localparam int unsigned QUEUE_DEPTH    = 32;
   localparam int unsigned PUSH_ROOM      = 9;
   localparam int unsigned POP_LEVEL      = 8;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [12:0] MAP_9800   = 13'h1800;
   localparam logic [12:0] MAP_9C00   = 13'h1C00;
   localparam logic [12:0] TILES_9000 = 13'h1000;
   localparam logic [12:0] TILES_8800 = 13'h0800;

   localparam int LCDC_ON    = 7;
   localparam int LCDC_TILES = 4;
   localparam int LCDC_MAP   = 3;
   localparam int LCDC_BG    = 0;

   localparam logic [3:0][23:0] SHADE_RGB = {
      24'h272818, 24'h686850, 24'hA0A088, 24'hC8C7A8
   };

   localparam rsp_type IDLE_AT_RESET = '{1'b0, 8'd0, 8'd0, 2'd0, 24'd0, 8'd0, VM_SEARCH};

   typedef struct packed {
      logic        kind;
      logic [12:0] addr;
      logic [7:0]  data;
      logic        typed_in;
      rsp_type     want;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   logic         req_kind;
   logic [12:0]  req_vram_address;
   logic [7:0]   req_vram_data;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic         rsp_pixel_valid;
   logic [7:0]   rsp_pixel_x;
   logic [7:0]   rsp_pixel_y;
   logic [1:0]   rsp_shade;
   logic [23:0]  rsp_rgb_colour;
   logic [7:0]   rsp_current_line;
   logic [1:0]   rsp_video_mode;
   logic         csr_write_enable;
   logic [1:0]   csr_index;
   logic [7:0]   csr_write_data;

   // sidecar of the payload: literal expectation for directed rows
   logic         row_literal;
   rsp_type      row_want;

   // predictor state
   logic [7:0]      cfg_lcdc, cfg_scx, cfg_scy, cfg_bgp;
   logic [7:0]      vram_image [VRAM_BYTES];
   video_mode_type  lcd_mode;
   logic [8:0]      dot_in_line;
   logic [7:0]      scan_line;
   logic [7:0]      emit_col;
   fetch_phase_type fetch_step;
   logic            fetch_second;
   logic [7:0]      fetch_x;
   logic [7:0]      map_tile;
   logic [2:0]      row_in_tile;
   logic [7:0]      plane_lo, plane_hi;
   logic [1:0]      colour_fifo [$];

   rsp_type         expected_scan_q [$];
   int              error_count = 0;
   int              send_pct = 0;
   int              stall_pct = 0;
   int              send_calm = 0;
   int              stall_calm = 0;

   stim_row_type    dir_rows [24];

   tile_background_pixel_pipeline dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_vram_address (req_vram_address),
      .req_vram_data    (req_vram_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_valid  (rsp_pixel_valid),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_shade        (rsp_shade),
      .rsp_rgb_colour   (rsp_rgb_colour),
      .rsp_current_line (rsp_current_line),
      .rsp_video_mode   (rsp_video_mode),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         $display("%0t mismatch %s: got %0h want %0h", $time, name, got, want);
         error_count++;
      end
   endtask

   function automatic logic [12:0] tile_plane_addr();
      logic [12:0] base;
      if (cfg_lcdc[LCDC_TILES])
         base = {1'b0, map_tile, 4'b0000};
      else if (!map_tile[7])
         base = TILES_9000 + {1'b0, map_tile, 4'b0000};
      else
         base = TILES_8800 + {2'b00, map_tile[6:0], 4'b0000};
      return base + {9'd0, row_in_tile, 1'b0};
   endfunction

   // advance the predicted pipeline by one item and return its result
   function automatic rsp_type run_dot(logic kind, logic [12:0] addr, logic [7:0] data);
      rsp_type    r;
      logic [7:0] ry, rx;
      logic [1:0] cidx;
      r = '0;
      if (kind == KIND_WRITE) begin
         vram_image[addr] = data;
      end else if (cfg_lcdc[LCDC_ON]) begin
         dot_in_line = dot_in_line + 9'd1;
         case (lcd_mode)
            VM_SEARCH: begin
               if (dot_in_line == SEARCH_DOTS) begin
                  colour_fifo.delete();
                  fetch_step = PH_INDEX;
                  fetch_second = 1'b0;
                  fetch_x = 8'd0;
                  lcd_mode = VM_TRANSFER;
               end
            end
            VM_TRANSFER: begin
               case (fetch_step) inside
                  PH_INDEX, PH_LOW, PH_HIGH: begin
                     if (!fetch_second) begin
                        fetch_second = 1'b1;
                     end else begin
                        fetch_second = 1'b0;
                        if (fetch_step == PH_INDEX) begin
                           ry = cfg_scy + scan_line;
                           rx = cfg_scx + fetch_x;
                           map_tile = vram_image[(cfg_lcdc[LCDC_MAP] ? MAP_9C00 : MAP_9800) +
                                                 {3'b000, ry[7:3], rx[7:3]}];
                           row_in_tile = ry[2:0];
                           fetch_x = fetch_x + 8'd8;
                           fetch_step = PH_LOW;
                        end else if (fetch_step == PH_LOW) begin
                           plane_lo = vram_image[tile_plane_addr()];
                           fetch_step = PH_HIGH;
                        end else begin
                           plane_hi = vram_image[tile_plane_addr() + 13'd1];
                           fetch_step = PH_WAIT;
                        end
                     end
                  end
                  PH_WAIT: begin
                     if (colour_fifo.size() <= PUSH_ROOM) fetch_step = PH_PUSH;
                  end
                  default: begin
                     fetch_step = PH_INDEX;
                     fetch_second = 1'b0;
                     for (int b = 7; b >= 0; b--)
                        if (colour_fifo.size() < QUEUE_DEPTH)
                           colour_fifo.push_back({plane_hi[b], plane_lo[b]});
                  end
               endcase
               if (colour_fifo.size() > POP_LEVEL) begin
                  cidx = colour_fifo.pop_front();
                  if (!cfg_lcdc[LCDC_BG]) cidx = 2'd0;
                  r.pixel_valid = 1'b1;
                  r.pixel_x = emit_col;
                  r.pixel_y = scan_line;
                  r.shade = cfg_bgp[cidx*2 +: 2];
                  r.rgb_colour = SHADE_RGB[r.shade];
                  emit_col = emit_col + 8'd1;
               end
               if (emit_col == SCREEN_COLUMNS) begin
                  emit_col = 8'd0;
                  lcd_mode = VM_HBLANK;
               end
            end
            VM_HBLANK: begin
               if (dot_in_line >= LINE_DOTS) begin
                  dot_in_line = 9'd0;
                  scan_line = scan_line + 8'd1;
                  lcd_mode = (scan_line == VISIBLE_LINES) ? VM_VBLANK : VM_SEARCH;
               end
            end
            default: begin
               if (dot_in_line >= LINE_DOTS) begin
                  dot_in_line = 9'd0;
                  scan_line = scan_line + 8'd1;
                  if (scan_line >= FRAME_LINES) begin
                     scan_line = 8'd0;
                     emit_col = 8'd0;
                     lcd_mode = VM_SEARCH;
                  end
               end
            end
         endcase
      end
      r.current_line = scan_line;
      r.video_mode = lcd_mode;
      return r;
   endfunction

   function automatic logic [7:0] pick_tile();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd2;
         3: return 8'd127;
         4: return 8'd128;
         5: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin : track
      rsp_type seen, due;
      if (reset) begin
         cfg_lcdc = LCDC_RESET;
         cfg_scx = 8'd0;
         cfg_scy = 8'd0;
         cfg_bgp = PALETTE_RESET;
         foreach (vram_image[i]) vram_image[i] = 8'd0;
         lcd_mode = VM_SEARCH;
         dot_in_line = 9'd0;
         scan_line = 8'd0;
         emit_col = 8'd0;
         fetch_step = PH_INDEX;
         fetch_second = 1'b0;
         fetch_x = 8'd0;
         map_tile = 8'd0;
         row_in_tile = 3'd0;
         plane_lo = 8'd0;
         plane_hi = 8'd0;
         colour_fifo.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LCD_CONTROL: cfg_lcdc = csr_write_data;
               CSR_SCROLL_X:    cfg_scx = csr_write_data;
               CSR_SCROLL_Y:    cfg_scy = csr_write_data;
               CSR_BG_PALETTE:  cfg_bgp = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            due = run_dot(req_kind, req_vram_address, req_vram_data);
            expected_scan_q.push_back(row_literal ? row_want : due);
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_pixel_valid, rsp_pixel_x, rsp_pixel_y, rsp_shade,
                     rsp_rgb_colour, rsp_current_line, rsp_video_mode};
            if (expected_scan_q.size() == 0) begin
               report_mismatch("result with none due", 32'd1, 32'd0);
            end else begin
               due = expected_scan_q.pop_front();
               report_mismatch("pixel_valid", seen.pixel_valid, due.pixel_valid);
               report_mismatch("pixel_x", seen.pixel_x, due.pixel_x);
               report_mismatch("pixel_y", seen.pixel_y, due.pixel_y);
               report_mismatch("shade", seen.shade, due.shade);
               report_mismatch("rgb_colour", seen.rgb_colour, due.rgb_colour);
               report_mismatch("current_line", seen.current_line, due.current_line);
               report_mismatch("video_mode", seen.video_mode, due.video_mode);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_calm > 0) begin
         stall_calm <= stall_calm - 1;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 79) == 0) begin
         stall_calm <= $urandom_range(10, 40);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_item(logic kind, logic [12:0] addr, logic [7:0] data,
                            logic lit, rsp_type want);
      if (send_calm > 0) begin
         send_calm--;
      end else if ($urandom_range(0, 59) == 0) begin
         send_calm = $urandom_range(8, 40);
      end else begin
         while ($urandom_range(0, 99) < send_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_vram_address <= addr;
      req_vram_data <= data;
      row_literal <= lit;
      row_want <= want;
      // stall is stable at the falling edge for the next rising edge
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   // hold off until every outstanding item has returned
   task automatic settle_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_scan_q.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_config(logic [7:0] lc, logic [7:0] sx, logic [7:0] sy, logic [7:0] pal);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_LCD_CONTROL;
      csr_write_data <= lc;
      @(posedge clock);
      csr_index <= CSR_SCROLL_X;
      csr_write_data <= sx;
      @(posedge clock);
      csr_index <= CSR_SCROLL_Y;
      csr_write_data <= sy;
      @(posedge clock);
      csr_index <= CSR_BG_PALETTE;
      csr_write_data <= pal;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0]  lc, sx, sy, pal, tile, row_sel;
      logic [12:0] addr;
      int          count;
      int unsigned pick;

      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_TICK;
      req_vram_address = 13'd0;
      req_vram_data = 8'd0;
      csr_write_enable = 1'b0;
      csr_index = CSR_LCD_CONTROL;
      csr_write_data = 8'd0;
      row_literal = 1'b0;
      row_want = '0;

      dir_rows = '{
         '{KIND_TICK,  13'h0000, 8'h00, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h0000, 8'hFF, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h1FFF, 8'hFF, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h1FFF, 8'h00, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h0000, 8'h00, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h1800, 8'h01, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h0010, 8'hFF, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h0011, 8'h55, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h1801, 8'h80, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h1C00, 8'h7F, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h0800, 8'hAA, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h17FF, 8'hFF, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h1555, 8'hAA, 1'b1, IDLE_AT_RESET},
         '{KIND_WRITE, 13'h0AAA, 8'h55, 1'b1, IDLE_AT_RESET},
         '{KIND_TICK,  13'h1FFF, 8'hFF, 1'b1, IDLE_AT_RESET},
         '{KIND_TICK,  13'h0AAA, 8'h55, 1'b0, '0},
         '{KIND_TICK,  13'h1555, 8'hAA, 1'b0, '0},
         '{KIND_WRITE, 13'h1000, 8'hC3, 1'b0, '0},
         '{KIND_TICK,  13'h0000, 8'h00, 1'b0, '0},
         '{KIND_TICK,  13'h0000, 8'h00, 1'b0, '0},
         '{KIND_WRITE, 13'h1C1F, 8'h80, 1'b0, '0},
         '{KIND_TICK,  13'h0000, 8'h00, 1'b0, '0},
         '{KIND_TICK,  13'h0000, 8'h00, 1'b0, '0},
         '{KIND_TICK,  13'h0000, 8'h00, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_pct = 28;
      stall_pct = 60;
      foreach (dir_rows[i])
         send_item(dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].data,
                   dir_rows[i].typed_in, dir_rows[i].want);

      for (int phase = 1; phase <= 7; phase++) begin
         settle_idle();
         sx = 8'($urandom);
         sy = 8'($urandom);
         pal = 8'($urandom);
         lc = 8'($urandom) | (8'd1 << LCDC_ON);
         count = 60;
         case (phase)
            1: begin
               lc = 8'h99; sx = 8'hFF; sy = 8'hFF; pal = 8'h1B; count = 90;
            end
            2: begin
               lc = 8'h81; sx = 8'h00; sy = 8'h00; pal = 8'hE4; count = 90;
            end
            3: begin
               lc = 8'h80; pal = 8'hFF; count = 90;
            end
            4: begin
               lc = 8'h00; count = 25;
            end
            5: begin
               lc = 8'hFF; pal = 8'h00; count = 90;
            end
            default: ;
         endcase
         if (phase <= 2) begin
            send_pct = 28;
            stall_pct = 60;
         end else if (phase <= 5) begin
            send_pct = 60;
            stall_pct = 28;
         end else begin
            send_pct = 0;
            stall_pct = 0;
         end
         write_config(lc, sx, sy, pal);

         for (int n = 0; n < count; n++) begin
            if (n == count / 2) settle_idle();
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               send_item(KIND_TICK, 13'($urandom), 8'($urandom), 1'b0, '0);
            end else if (pick < 80) begin
               row_sel = cfg_scy + scan_line;
               addr = ($urandom_range(0, 1) ? MAP_9C00 : MAP_9800) +
                      {3'b000, row_sel[7:3], 5'($urandom)};
               send_item(KIND_WRITE, addr, pick_tile(), 1'b0, '0);
            end else if (pick < 95) begin
               tile = pick_tile();
               if ($urandom_range(0, 1))
                  addr = {1'b0, tile, 4'($urandom)};
               else if (!tile[7])
                  addr = TILES_9000 + {1'b0, tile, 4'($urandom)};
               else
                  addr = TILES_8800 + {2'b00, tile[6:0], 4'($urandom)};
               send_item(KIND_WRITE, addr, 8'($urandom), 1'b0, '0);
            end else begin
               send_item(KIND_WRITE, 13'($urandom), 8'($urandom), 1'b0, '0);
            end
         end
      end

      settle_idle();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
